// ===== rtl/core/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// psf_pkg: shared types and constants
// Widths, opcodes and default register values for the span filler.
// ----------------------------------------------------------------------------
package psf_pkg;

	localparam int CoordW = 16;
	localparam int DefMaxVertices = 16;
	localparam int MaxResults = 8;
	localparam int MinPolyVertices = 3;
	localparam int CfgIdxW = 2;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_APPEND = 2'd1,
		OP_ROW    = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_CLIP_LEFT   = 2'd0,
		REG_CLIP_TOP    = 2'd1,
		REG_CLIP_RIGHT  = 2'd2,
		REG_CLIP_BOTTOM = 2'd3
	} cfg_idx_t;

	localparam logic signed [CoordW-1:0] ClipMinDefault = 16'sh8000;
	localparam logic signed [CoordW-1:0] ClipMaxDefault = 16'sh7fff;

endpackage

// ===== rtl/core/psf_div.sv =====
// ----------------------------------------------------------------------------
// psf_div: signed restoring divider
// One quotient bit per cycle, truncated toward zero, 33-bit dividend.
// ----------------------------------------------------------------------------
module psf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] dividend,
	input  logic signed [16:0] divisor,
	output logic               done,
	output logic signed [32:0] quotient
);
	logic [32:0] rem_q;
	logic [32:0] quo_q;
	logic [16:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        neg_q;
	logic [33:0] trial;
	logic [32:0] shifted;

	// Shift in the next dividend bit and try a subtraction.
	assign shifted = {rem_q[31:0], quo_q[32]};
	assign trial   = {1'b0, shifted} - {17'd0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// Magnitudes are loaded at start; the sign is restored at the end.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[32] ? 33'(-dividend) : dividend;
			dvs_q <= divisor[16] ? 17'(-divisor) : divisor;
			neg_q <= dividend[32] ^ divisor[16];
		end else if (busy_q) begin
			if (!trial[33]) rem_q <= trial[32:0];
			else rem_q <= shifted;
			quo_q <= {quo_q[31:0], ~trial[33]};
		end
	end

	assign quotient = neg_q ? 33'(-quo_q) : quo_q;
endmodule

// ===== rtl/core/psf_core.sv =====
// ----------------------------------------------------------------------------
// psf_core: vertex store and row sequencer
// Holds the vertex memory, walks edges, sorts crossings and emits spans.
// ----------------------------------------------------------------------------
module psf_core #(
	parameter int MaxVertices = psf_pkg::DefMaxVertices
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic signed [psf_pkg::CoordW-1:0]  coord_x,
	input  logic signed [psf_pkg::CoordW-1:0]  coord_y,
	input  logic signed [psf_pkg::CoordW-1:0]  clip_left,
	input  logic signed [psf_pkg::CoordW-1:0]  clip_top,
	input  logic signed [psf_pkg::CoordW-1:0]  clip_right,
	input  logic signed [psf_pkg::CoordW-1:0]  clip_bottom,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [psf_pkg::CoordW-1:0]  span_left,
	output logic signed [psf_pkg::CoordW-1:0]  span_right,
	output logic signed [psf_pkg::CoordW-1:0]  span_row,
	output logic                               last_span
);
	import psf_pkg::*;

	localparam int AW = $clog2(MaxVertices);
	localparam int CW = $clog2(MaxVertices + 1);
	localparam int XN = MaxVertices;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_RD0   = 8'b0000_0010,
		ST_RDA   = 8'b0000_0100,
		ST_EDGE  = 8'b0000_1000,
		ST_DIV   = 8'b0001_0000,
		ST_SORT  = 8'b0010_0000,
		ST_PAIR  = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Vertex memory: one write port, one registered read port.
	logic [2*CoordW-1:0] vmem [MaxVertices];
	logic [2*CoordW-1:0] rd_data;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;

	logic [CW-1:0] count_q;
	logic [CW-1:0] edge_q;
	logic signed [CoordW-1:0] row_q;
	logic signed [CoordW-1:0] fx_q, fy_q, ax_q, ay_q, bx_q, by_q;

	logic signed [CoordW-1:0] xs_q [XN];
	logic [CW-1:0] nx_q;
	logic [CW-1:0] pass_q;
	logic [CW-1:0] pair_q;
	logic [3:0]    nspan_q;

	logic signed [CoordW-1:0] sl_q [MaxResults];
	logic signed [CoordW-1:0] sr_q [MaxResults];
	logic [3:0] emit_q;

	logic div_start, div_done;
	logic div_start_s1;
	logic signed [32:0] div_quo;
	logic signed [32:0] prod_s1;
	logic signed [16:0] dden_s1;

	logic accept;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Vertex writes happen on accepted start or append items.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		if (accept && opcode == OP_START) begin
			wr_en = 1'b1;
		end else if (accept && opcode == OP_APPEND && count_q < CW'(MaxVertices)) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) vmem[wr_addr] <= {coord_x, coord_y};
		rd_data <= vmem[rd_addr];
	end

	// Edge end b is the next vertex, wrapping to vertex 0.
	logic [CW-1:0] next_edge;
	assign next_edge = edge_q + CW'(1);
	assign rd_addr = (state_q == ST_IDLE || state_q == ST_RD0) ? '0 : next_edge[AW-1:0];

	// Edge test and product, registered into the divider.
	logic signed [CoordW-1:0] ex1, ey1;
	logic hit;
	logic signed [16:0] dy_d, dx_d;
	logic signed [32:0] prod_d;
	assign ex1 = (next_edge == count_q) ? fx_q : $signed(rd_data[2*CoordW-1:CoordW]);
	assign ey1 = (next_edge == count_q) ? fy_q : $signed(rd_data[CoordW-1:0]);
	assign hit = (ay_q != ey1) &&
		((row_q >= ay_q && row_q < ey1) || (row_q >= ey1 && row_q < ay_q));
	assign dy_d   = 17'(row_q) - 17'(ay_q);
	assign dx_d   = 17'(ex1) - 17'(ax_q);
	assign prod_d = dy_d * dx_d;

	// New crossing x: edge start x plus the divider quotient.
	logic signed [CoordW-1:0] newx;
	assign newx = CoordW'(ax_q + div_quo[CoordW-1:0]);

	// Pair clipping.
	logic signed [CoordW-1:0] pl, pr;
	always_comb begin
		pl = xs_q[pair_q[AW-1:0]];
		pr = xs_q[AW'(pair_q + CW'(1))];
		if (pl < clip_left) pl = clip_left;
		if (pr > clip_right) pr = clip_right;
	end

	assign div_start = (state_q == ST_EDGE) && hit && (pass_q == CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (opcode)
							OP_START: count_q <= CW'(1);
							OP_APPEND: if (count_q < CW'(MaxVertices)) count_q <= count_q + CW'(1);
							OP_ROW: if (count_q >= CW'(MinPolyVertices) &&
								coord_y >= clip_top && coord_y <= clip_bottom)
								state_q <= ST_RD0;
							default: ;
						endcase
					end
				end
				ST_RD0: state_q <= ST_RDA;
				ST_RDA: state_q <= ST_EDGE;
				ST_EDGE: begin
					if (pass_q == CW'(0)) state_q <= ST_EDGE;
					else if (hit) state_q <= ST_DIV;
					else if (next_edge == count_q) state_q <= ST_SORT;
					else state_q <= ST_EDGE;
				end
				ST_DIV: if (div_done) state_q <= ST_SORT;
				ST_SORT: if (pass_q == CW'(0)) begin
					if (edge_q == count_q) state_q <= ST_PAIR;
					else state_q <= ST_EDGE;
				end
				ST_PAIR: if (pair_q + CW'(1) >= nx_q || nspan_q == 4'(MaxResults)) begin
					if (nspan_q == 4'd0 && !(pair_q + CW'(1) < nx_q && pr >= pl))
						state_q <= ST_IDLE;
					else state_q <= ST_EMIT;
				end
				ST_EMIT: if (!out_valid || !out_stall) begin
					if (emit_q == nspan_q) begin
						if (!out_valid || !out_stall) begin
							out_valid <= 1'b0;
							state_q <= ST_IDLE;
						end
					end else begin
						out_valid <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				row_q  <= coord_y;
				edge_q <= '0;
				nx_q   <= '0;
				pass_q <= '0;
				pair_q <= '0;
				nspan_q <= '0;
				emit_q <= '0;
			end
			ST_RD0: ;
			ST_RDA: begin
				// Vertex 0 is both first edge start and closing edge end.
				fx_q <= $signed(rd_data[2*CoordW-1:CoordW]);
				fy_q <= $signed(rd_data[CoordW-1:0]);
				ax_q <= $signed(rd_data[2*CoordW-1:CoordW]);
				ay_q <= $signed(rd_data[CoordW-1:0]);
				pass_q <= '0;
			end
			ST_EDGE: begin
				if (pass_q == CW'(0)) begin
					// Read of the edge end lands this cycle.
					pass_q <= CW'(1);
				end else begin
					bx_q <= ex1;
					by_q <= ey1;
					prod_s1 <= prod_d;
					dden_s1 <= 17'(ey1) - 17'(ay_q);
					if (!hit) begin
						ax_q <= ex1;
						ay_q <= ey1;
						edge_q <= next_edge;
						pass_q <= '0;
					end
				end
			end
			ST_DIV: if (div_done) begin
				// Insert the new crossing at the list tail; the sort step sinks it.
				xs_q[nx_q[AW-1:0]] <= newx;
				nx_q <= nx_q + CW'(1);
				ax_q <= bx_q;
				ay_q <= by_q;
				edge_q <= next_edge;
				pass_q <= (nx_q + CW'(1) > CW'(1)) ? nx_q : '0;
			end
			ST_SORT: if (pass_q != CW'(0)) begin
				// One bubble step per cycle moving the newest entry down.
				if (xs_q[AW'(pass_q - CW'(1))] > xs_q[pass_q[AW-1:0]]) begin
					xs_q[AW'(pass_q - CW'(1))] <= xs_q[pass_q[AW-1:0]];
					xs_q[pass_q[AW-1:0]] <= xs_q[AW'(pass_q - CW'(1))];
					pass_q <= pass_q - CW'(1);
				end else pass_q <= '0;
			end
			ST_PAIR: begin
				if (pair_q + CW'(1) < nx_q && nspan_q != 4'(MaxResults)) begin
					if (pr >= pl) begin
						sl_q[nspan_q[2:0]] <= pl;
						sr_q[nspan_q[2:0]] <= pr;
						nspan_q <= nspan_q + 4'd1;
					end
					pair_q <= pair_q + CW'(2);
				end
			end
			ST_EMIT: if (!out_valid || !out_stall) begin
				if (emit_q != nspan_q) begin
					span_left  <= sl_q[emit_q[2:0]];
					span_right <= sr_q[emit_q[2:0]];
					span_row   <= row_q;
					last_span  <= (emit_q + 4'd1 == nspan_q);
					emit_q <= emit_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	psf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_s1),
		.dividend (prod_s1),
		.divisor  (dden_s1),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Divider starts in the cycle after the product register loads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_start_s1 <= 1'b0;
		else div_start_s1 <= div_start;
	end
endmodule

// ===== rtl/core/polygon_scanline_span_fill.sv =====
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill: even-odd scanline polygon filler
// Top level with the clip registers and the span sequencer.
// ----------------------------------------------------------------------------
// Vertex items, unused opcodes and row items that fail the vertex count or
// clip row test are taken while idle and can follow back to back. Any other
// row item fetches vertex 0, reads each edge, runs the 33-step bit-serial
// divider for each edge that crosses the row, sinks each new crossing into
// the sorted list, pairs the crossings and emits the clipped spans.
// Input is stalled for the whole row, and output stalls add their length.
module polygon_scanline_span_fill #(
	parameter int MaxVertices = psf_pkg::DefMaxVertices
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [psf_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [psf_pkg::CoordW-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic signed [psf_pkg::CoordW-1:0] coord_x,
	input  logic signed [psf_pkg::CoordW-1:0] coord_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [psf_pkg::CoordW-1:0] span_left,
	output logic signed [psf_pkg::CoordW-1:0] span_right,
	output logic signed [psf_pkg::CoordW-1:0] span_row,
	output logic                              last_span
);
	import psf_pkg::*;

	logic signed [CoordW-1:0] left_q, top_q, right_q, bottom_q;

	// Clip rectangle registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= ClipMinDefault;
			top_q    <= ClipMinDefault;
			right_q  <= ClipMaxDefault;
			bottom_q <= ClipMaxDefault;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_CLIP_LEFT:   left_q   <= cfg_data;
				REG_CLIP_TOP:    top_q    <= cfg_data;
				REG_CLIP_RIGHT:  right_q  <= cfg_data;
				REG_CLIP_BOTTOM: bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	psf_core #(.MaxVertices(MaxVertices)) u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .coord_x(coord_x), .coord_y(coord_y),
		.clip_left(left_q), .clip_top(top_q),
		.clip_right(right_q), .clip_bottom(bottom_q),
		.out_valid(out_valid), .out_stall(out_stall),
		.span_left(span_left), .span_right(span_right),
		.span_row(span_row), .last_span(last_span)
	);
endmodule

// ===== sim/polygon_scanline_span_fill_test.sv =====
// ----------------------------------------------------------------------------
// polygon_scanline_span_fill_test: span filler testbench
// Drives vertex and row items in random bursts and checks every emitted span
// against a predictor of the even-odd fill, clipping included.
// ----------------------------------------------------------------------------
module polygon_scanline_span_fill_test;
	timeunit 1ns;
	timeprecision 1ps;
	import psf_pkg::*;

	typedef struct packed {
		logic [1:0]        op;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} item_t;

	typedef struct packed {
		logic signed [15:0] l;
		logic signed [15:0] r;
		logic signed [15:0] row;
		logic               last;
	} span_t;

	localparam int CycleLimit = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CoordW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = '0;
	logic signed [15:0] coord_x = '0;
	logic signed [15:0] coord_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] span_left, span_right, span_row;
	logic last_span;

	polygon_scanline_span_fill u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	item_t pending_items[$];
	span_t expected_spans[$];
	int errors = 0;
	int cycles = 0;
	bit hold_sender = 1'b0;
	bit in_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;

	// Predictor state.
	int p_left = -32768, p_top = -32768, p_right = 32767, p_bottom = 32767;
	int vx[16], vy[16];
	int vcount = 0;

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	// Applies one item to the predictor: stores vertices, or computes the spans of a row and queues them.
	task automatic predict_spans(item_t it);
		int xs[16];
		int nx, j, x0, y0, x1, y1, v, b, l, r, cnt, yy;
		longint num;
		span_t s;
		nx = 0;
		cnt = 0;
		yy = it.y;
		case (it.op)
			OP_START: begin
				vx[0] = it.x; vy[0] = it.y; vcount = 1;
			end
			OP_APPEND: begin
				if (vcount < 16) begin
					vx[vcount] = it.x; vy[vcount] = it.y; vcount++;
				end
			end
			OP_ROW: begin
				if (vcount >= 3 && yy >= p_top && yy <= p_bottom) begin
					for (int i = 0; i < vcount; i++) begin
						j = (i + 1 == vcount) ? 0 : i + 1;
						x0 = vx[i]; y0 = vy[i]; x1 = vx[j]; y1 = vy[j];
						if (y0 != y1 && ((yy >= y0 && yy < y1) || (yy >= y1 && yy < y0))) begin
							num = longint'(yy - y0) * longint'(x1 - x0);
							xs[nx] = x0 + int'(num / longint'(y1 - y0));
							nx++;
						end
					end
					for (int a = 1; a < nx; a++) begin
						v = xs[a];
						b = a;
						while (b > 0 && xs[b-1] > v) begin
							xs[b] = xs[b-1];
							b--;
						end
						xs[b] = v;
					end
					for (int a = 0; a + 1 < nx && cnt < MaxResults; a += 2) begin
						l = (xs[a] < p_left) ? p_left : xs[a];
						r = (xs[a+1] > p_right) ? p_right : xs[a+1];
						if (r >= l) begin
							s.l = 16'(l); s.r = 16'(r); s.row = 16'(yy); s.last = 1'b0;
							expected_spans.push_back(s);
							cnt++;
						end
					end
					if (cnt > 0) expected_spans[$].last = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	// Driver: bursts with random gaps, fed from the pending queue, plus output stall patterns.
	always @(negedge clk) begin
		cycles <= cycles + 1;
		if (!in_valid || in_taken) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			end
			if (!hold_sender && pending_items.size() > 0 && (burst_left > 0)) begin
				opcode <= pending_items[0].op;
				coord_x <= pending_items[0].x;
				coord_y <= pending_items[0].y;
				in_valid <= 1'b1;
				burst_left--;
			end else begin
				in_valid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end
		end
		case (cycles % 300 / 50)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) == 0);
			2: out_stall <= ((cycles % 7) < 5);
			default: out_stall <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Monitor: accept input items into the predictor, check spans.
	always @(posedge clk) begin
		span_t w;
		in_taken = arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			predict_spans(pending_items.pop_front());
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_spans.size() == 0) begin
				report("unexpected span row", span_row, 0);
			end else begin
				w = expected_spans.pop_front();
				if (span_left !== w.l) report("span_left", span_left, w.l);
				if (span_right !== w.r) report("span_right", span_right, w.r);
				if (span_row !== w.row) report("span_row", span_row, w.row);
				if (last_span !== w.last) report("last_span", last_span, w.last);
			end
		end
		if (cycles > CycleLimit) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic item_t mk(logic [1:0] op, int x, int y);
		item_t it;
		it.op = op; it.x = 16'(x); it.y = 16'(y);
		return it;
	endfunction

	function automatic int rcoord(int spread);
		if ($urandom_range(0, 9) == 0) return $signed(16'($urandom()));
		return int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	// Waits until every queued item is accepted, the block is idle and every
	// span has arrived.
	task automatic drain();
		@(negedge clk);
		while (pending_items.size() > 0 || expected_spans.size() > 0 || in_valid || in_stall)
			@(negedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CLIP_LEFT: p_left = $signed(16'(value));
			REG_CLIP_TOP: p_top = $signed(16'(value));
			REG_CLIP_RIGHT: p_right = $signed(16'(value));
			default: p_bottom = $signed(16'(value));
		endcase
	endtask

	task automatic random_polygon(int spread, int rows);
		int n, cy;
		n = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 18);
		cy = rcoord(spread);
		pending_items.push_back(mk($urandom_range(0, 5) == 0 ? OP_APPEND : OP_START,
			rcoord(spread), cy));
		for (int i = 1; i < n; i++)
			pending_items.push_back(mk(OP_APPEND, rcoord(spread), cy + rcoord(spread)));
		for (int i = 0; i < rows; i++) begin
			if ($urandom_range(0, 15) == 0)
				pending_items.push_back(mk(OP_NONE, rcoord(spread), rcoord(spread)));
			else
				pending_items.push_back(mk(OP_ROW, 0, cy + rcoord(spread)));
		end
	endtask

	initial begin
		int plan;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, overflow, odd crossings, degenerate and unused ops.
		pending_items.push_back(mk(OP_ROW, 0, 0));
		pending_items.push_back(mk(OP_APPEND, -32768, -32768));
		pending_items.push_back(mk(OP_APPEND, 32767, -32768));
		pending_items.push_back(mk(OP_ROW, 0, -32768));
		pending_items.push_back(mk(OP_APPEND, 0, 32767));
		pending_items.push_back(mk(OP_ROW, 16'hffff, -32768));
		pending_items.push_back(mk(OP_ROW, 0, 0));
		pending_items.push_back(mk(OP_ROW, 0, 32766));
		pending_items.push_back(mk(OP_ROW, 0, 32767));
		pending_items.push_back(mk(OP_NONE, -1, -1));
		pending_items.push_back(mk(OP_START, 0, 0));
		for (int i = 1; i < 18; i++)
			pending_items.push_back(mk(OP_APPEND, (i % 2) ? 100 * i : -7 * i, (i % 2) ? 30 : -30 + i));
		pending_items.push_back(mk(OP_ROW, 0, 0));
		pending_items.push_back(mk(OP_ROW, 0, 5));
		drain();

		// Random phases under several clip windows.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_CLIP_LEFT, -32768); write_reg(REG_CLIP_TOP, -32768);
					write_reg(REG_CLIP_RIGHT, 32767); write_reg(REG_CLIP_BOTTOM, 32767);
				end
				1: begin
					write_reg(REG_CLIP_LEFT, -50); write_reg(REG_CLIP_TOP, -40);
					write_reg(REG_CLIP_RIGHT, 60); write_reg(REG_CLIP_BOTTOM, 45);
				end
				2: begin
					write_reg(REG_CLIP_LEFT, 32767); write_reg(REG_CLIP_RIGHT, -32768);
				end
				3: begin
					write_reg(REG_CLIP_LEFT, rcoord(200)); write_reg(REG_CLIP_RIGHT, rcoord(200));
					write_reg(REG_CLIP_TOP, rcoord(100)); write_reg(REG_CLIP_BOTTOM, 32767);
				end
				4: begin
					write_reg(REG_CLIP_LEFT, 0); write_reg(REG_CLIP_RIGHT, 0);
					write_reg(REG_CLIP_TOP, 32767); write_reg(REG_CLIP_BOTTOM, -32768);
				end
				default: begin
					write_reg(REG_CLIP_LEFT, -32768); write_reg(REG_CLIP_TOP, -32768);
					write_reg(REG_CLIP_RIGHT, 32767); write_reg(REG_CLIP_BOTTOM, 32767);
				end
			endcase
			plan = 0;
			while (plan < 36) begin
				random_polygon(ph == 5 ? 30000 : 100, $urandom_range(2, 5));
				plan = plan + 12;
			end
			if (ph == 3) begin
				// Hold the sender until the block has gone quiet.
				hold_sender = 1'b1;
				while (expected_spans.size() > 0 || in_valid) @(posedge clk);
				hold_sender = 1'b0;
			end
			drain();
		end

		if (errors == 0 && expected_spans.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
